@@ hdl/bfiq_pkg.sv @@
package bfiq_pkg;

    localparam int LOG2_MAX_BITS = 16;
    localparam int LOG2_MIN_BITS = 3;
    localparam int CFG_W         = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int HASH_W        = 32;
    localparam int COUNT_W       = 17;
    localparam int POS_W         = LOG2_MAX_BITS;
    localparam int LOG2_ROW_W    = (LOG2_MAX_BITS > 5) ? 5 : LOG2_MAX_BITS - 1;
    localparam int ROW_W         = 1 << LOG2_ROW_W;
    localparam int ROW_ADDR_W    = POS_W - LOG2_ROW_W;
    localparam int ROW_CNT       = 1 << ROW_ADDR_W;

    localparam logic [CFG_IDX_W-1:0] REG_LOG2_BITS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES = 1'b1;

    localparam logic [CFG_W-1:0]   LOG2_BITS_RST  = 5'd16;
    localparam logic [CFG_W-1:0]   NUM_HASHES_RST = 5'd7;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 17'h1FFFF;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic clr;
        logic load;
        logic chk;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic no_probes;
        logic bit_clear;
        logic last_probe;
        logic insert;
    } t_sts;

endpackage

@@ hdl/bloom_filter_insert_query.sv @@
// channel  direction  handshake                 payload
// cfg      in         i_cfg_we                  i_cfg_index, i_cfg_data
// in       in         i_in_valid / o_in_ready   i_opcode, i_hash_a, i_hash_b
// out      out        o_out_valid / i_out_ready o_answer, o_entry_count
//
// an item is accepted, then each probe takes one read and one check/write
// on the single bit-store port, then the result register is loaded once it is free
// a query stops at its first clear bit; num_hashes zero skips the probes
// after reset a clearing pass over all 2048 rows (one 32-bit row per cycle) runs
// with o_in_ready low; configuration writes are taken throughout
// a stalled result holds in the output register while the next beat is taken
module bloom_filter_insert_query
    import bfiq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic [HASH_W-1:0]    i_hash_a,
    input  logic [HASH_W-1:0]    i_hash_b,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_answer,
    output logic [COUNT_W-1:0]   o_entry_count
);

    t_cmd cmd;
    t_sts sts;

    bfiq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bfiq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_hash_a      (i_hash_a),
        .i_hash_b      (i_hash_b),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_answer      (o_answer),
        .o_entry_count (o_entry_count)
    );

endmodule

@@ hdl/bfiq_ctrl.sv @@
module bfiq_ctrl
    import bfiq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.no_probes ? S_FIN : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if ((i_sts.bit_clear && !i_sts.insert) || i_sts.last_probe) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/bfiq_dp.sv @@
module bfiq_dp
    import bfiq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_opcode,
    input  logic [HASH_W-1:0]    i_hash_a,
    input  logic [HASH_W-1:0]    i_hash_b,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_answer,
    output logic [COUNT_W-1:0]   o_entry_count
);

    logic [ROW_W-1:0]      mem [ROW_CNT];
    logic [ROW_W-1:0]      r_rdata;

    logic [CFG_W-1:0]      r_log2_bits;
    logic [CFG_W-1:0]      r_num_hashes;
    logic [ROW_ADDR_W-1:0] r_clr_row;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      r_stride;
    logic [CFG_W-1:0]      r_probe;
    logic                  r_insert;
    logic                  r_all_set;
    logic                  r_any_clear;
    logic                  r_answer;
    logic [COUNT_W-1:0]    r_entry_count;

    logic [CFG_W-1:0]      size_log2;
    logic [POS_W-1:0]      mask;
    logic [POS_W-1:0]      addr;
    logic [ROW_ADDR_W-1:0] row;
    logic [LOG2_ROW_W-1:0] bit_sel;
    logic                  bit_clear;
    logic                  mem_we;
    logic [ROW_ADDR_W-1:0] mem_addr;
    logic [ROW_W-1:0]      mem_wdata;

    always_comb begin
        if (r_log2_bits < CFG_W'(LOG2_MIN_BITS)) begin
            size_log2 = CFG_W'(LOG2_MIN_BITS);
        end else if (r_log2_bits > CFG_W'(LOG2_MAX_BITS)) begin
            size_log2 = CFG_W'(LOG2_MAX_BITS);
        end else begin
            size_log2 = r_log2_bits;
        end
        for (int j = 0; j < POS_W; j++) begin
            mask[j] = (CFG_W'(j) < size_log2);
        end
    end

    assign addr      = r_pos & mask;
    assign row       = addr[POS_W-1:LOG2_ROW_W];
    assign bit_sel   = addr[LOG2_ROW_W-1:0];
    assign bit_clear = !r_rdata[bit_sel];

    assign mem_we    = i_cmd.clr || (i_cmd.chk && r_insert && bit_clear);
    assign mem_addr  = i_cmd.clr ? r_clr_row : row;
    assign mem_wdata = i_cmd.clr ? '0 : (r_rdata | (ROW_W'(1) << bit_sel));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_bits  <= LOG2_BITS_RST;
            r_num_hashes <= NUM_HASHES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LOG2_BITS:  r_log2_bits  <= i_cfg_data;
                REG_NUM_HASHES: r_num_hashes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        if (r_insert && r_any_clear && (r_count != COUNT_MAX)) begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
            r_count   <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_row <= r_clr_row + ROW_ADDR_W'(1);
            end
            if (i_cmd.fin) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_insert    <= (i_opcode == OP_INSERT);
            r_pos       <= i_hash_a[POS_W-1:0];
            r_stride    <= i_hash_b[POS_W-1:0];
            r_probe     <= '0;
            r_all_set   <= 1'b1;
            r_any_clear <= 1'b0;
        end else if (i_cmd.chk) begin
            r_pos   <= r_pos + r_stride;
            r_probe <= r_probe + CFG_W'(1);
            if (bit_clear) begin
                r_all_set   <= 1'b0;
                r_any_clear <= 1'b1;
            end
        end
        if (i_cmd.fin) begin
            r_answer      <= r_insert ? r_any_clear : r_all_set;
            r_entry_count <= n_count;
        end
    end

    assign o_sts.clr_last   = &r_clr_row;
    assign o_sts.no_probes  = (r_num_hashes == '0);
    assign o_sts.bit_clear  = bit_clear;
    assign o_sts.last_probe = ((r_probe + CFG_W'(1)) == r_num_hashes);
    assign o_sts.insert     = r_insert;

    assign o_answer      = r_answer;
    assign o_entry_count = r_entry_count;

endmodule

@@ hdl/bfiq_checker.sv @@
module bfiq_checker
    import bfiq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_answer,
    input logic [COUNT_W-1:0]   o_entry_count
);

    // result beat stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before accept");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_answer) && $stable(o_entry_count))
        else $error("stalled result beat changed");

    // reset starts the clearing pass with both channels quiet
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("channel active right after reset");

    // entry count never goes down
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> o_entry_count >= $past(o_entry_count))
        else $error("entry count decreased");

endmodule

bind bloom_filter_insert_query bfiq_checker u_bfiq_checker (.*);
